// File: rtl/touch_sample_average_scale_top_defines.svh
`ifndef TOUCH_SAMPLE_AVERAGE_SCALE_TOP_DEFINES_SVH
`define TOUCH_SAMPLE_AVERAGE_SCALE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TSAS_ASSERT_IMPLY(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("tsas same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define TSAS_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("tsas next-cycle check failed");

`endif

// File: rtl/tsas_pkg.sv
`timescale 1ns / 1ps

package tsas_pkg;

    localparam int WORD_W        = 16;
    localparam int READ_W        = 12;
    localparam int READ_LSB      = 3;
    // burst length, a power of two so the mean is a plain shift
    localparam int BURST_SAMPLES = 16;
    localparam int CNT_W         = $clog2(BURST_SAMPLES);
    localparam int TOTAL_W       = READ_W + CNT_W;
    localparam int STEP_W        = $clog2(READ_W);
    localparam int PROD_W        = 2 * READ_W;

    localparam int CFG_IDX_W     = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SPAN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SPAN = 3'd5;

    localparam logic [READ_W-1:0] RST_LOW   = 12'd0;
    localparam logic [READ_W-1:0] RST_HIGH  = 12'd4095;
    localparam logic [READ_W-1:0] RST_XSPAN = 12'd320;
    localparam logic [READ_W-1:0] RST_YSPAN = 12'd240;

    typedef struct packed {
        logic [READ_W-1:0] lo;
        logic [READ_W-1:0] hi;
        logic [READ_W-1:0] span;
    } axis_cfg_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_LOAD,
        SC_MUL,
        SC_DIV,
        SC_DONE
    } scale_phase_t;

    typedef enum logic {
        TS_IDLE,
        TS_CALC
    } top_state_t;

endpackage

// File: rtl/tsas_scale.sv
`timescale 1ns / 1ps

module tsas_scale (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start_i,
    input  logic [tsas_pkg::READ_W-1:0] mean_i,
    input  tsas_pkg::axis_cfg_t       cfg_i,
    output logic                      done_o,
    output logic [tsas_pkg::READ_W-1:0] coord_o
);
    import tsas_pkg::*;

    scale_phase_t       phase_reg, phase_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [READ_W-1:0]  mean_reg, mean_next;
    logic [READ_W-1:0]  num_reg, num_next;
    logic [READ_W-1:0]  den_reg, den_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;

    logic [READ_W-1:0]  clamped;
    logic [READ_W:0]    mul_sum;
    logic [READ_W:0]    div_trial;
    logic [READ_W:0]    div_diff;
    logic               div_ge;
    logic               last_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= SC_IDLE;
            step_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        mean_reg <= mean_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        prod_reg <= prod_next;
    end

    always_comb begin
        if (mean_reg < cfg_i.lo) begin
            clamped = cfg_i.lo;
        end else if (mean_reg > cfg_i.hi) begin
            clamped = cfg_i.hi;
        end else begin
            clamped = mean_reg;
        end
        // shift-add multiply: one bit of span per step, product builds from the top
        mul_sum   = {1'b0, prod_reg[PROD_W-1:READ_W]}
                  + (prod_reg[0] ? {1'b0, num_reg} : '0);
        // restoring divide: remainder in the top half, quotient shifts in at the bottom
        div_trial = {prod_reg[PROD_W-1:READ_W], prod_reg[READ_W-1]};
        div_diff  = div_trial - {1'b0, den_reg};
        div_ge    = (div_trial >= {1'b0, den_reg});
        last_step = (step_reg == STEP_W'(READ_W - 1));
    end

    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        mean_next  = mean_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        prod_next  = prod_reg;
        done_o     = 1'b0;
        case (phase_reg)
            SC_IDLE: begin
                if (start_i) begin
                    mean_next  = mean_i;
                    phase_next = SC_LOAD;
                end
            end
            SC_LOAD: begin
                num_next   = clamped - cfg_i.lo;
                den_next   = cfg_i.hi - cfg_i.lo;
                prod_next  = {{READ_W{1'b0}}, cfg_i.span};
                step_next  = '0;
                phase_next = SC_MUL;
            end
            SC_MUL: begin
                prod_next = {mul_sum, prod_reg[READ_W-1:1]};
                if (last_step) begin
                    step_next  = '0;
                    phase_next = SC_DIV;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            SC_DIV: begin
                // product < den * 2^12, so twelve quotient bits are enough
                if (div_ge) begin
                    prod_next = {div_diff[READ_W-1:0], prod_reg[READ_W-2:0], 1'b1};
                end else begin
                    prod_next = {div_trial[READ_W-1:0], prod_reg[READ_W-2:0], 1'b0};
                end
                if (last_step) begin
                    step_next  = '0;
                    phase_next = SC_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            SC_DONE: begin
                done_o     = 1'b1;
                phase_next = SC_IDLE;
            end
            default: begin
                phase_next = SC_IDLE;
            end
        endcase
    end

    assign coord_o = prod_reg[READ_W-1:0];

endmodule

// File: rtl/touch_sample_average_scale_top.sv
`timescale 1ns / 1ps

// channel  | dir | tvalid/tready/tdata/tuser
// s_       | in  | tdata {y_word, x_word}, tuser {pressed}
// m_       | out | tdata {screen_y, screen_x}, tuser {bad_calibration, touched}
// cfg_     | in  | cfg_index, cfg_data (12 bit), always ready
//
// a pressed item that does not end a burst only adds to the count and totals,
// a released item registers a zeroed not-touched result, and the item ending a
// burst starts both axis units; the result is registered after the load, the 12
// bit-serial multiply steps, 12 restoring divide steps and done phase of each unit
// reset clears count, totals, the output valid and loads the default calibration
// s_tready is low while the units run or while an unaccepted result is held

module touch_sample_average_scale_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // x_word[15:0], y_word[31:16]
    input  logic                           s_tuser,   // pressed
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // screen_x[11:0], screen_y[23:12]
    output logic [1:0]                     m_tuser,   // touched[0], bad_calibration[1]
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tsas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsas_pkg::READ_W-1:0]    cfg_data
);
    import tsas_pkg::*;

    top_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOTAL_W-1:0] xtot_reg, xtot_next;
    logic [TOTAL_W-1:0] ytot_reg, ytot_next;
    logic               mvalid_reg, mvalid_next;
    logic [23:0]        mdata_reg, mdata_next;
    logic [1:0]         muser_reg, muser_next;

    axis_cfg_t          xcfg_reg, ycfg_reg;

    logic [READ_W-1:0]  x_read, y_read;
    logic [TOTAL_W-1:0] x_sum, y_sum;
    logic               s_hs;
    logic               start;
    logic               x_done, y_done;
    logic [READ_W-1:0]  x_coord, y_coord;
    logic               bad_cal;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xcfg_reg <= '{lo: RST_LOW, hi: RST_HIGH, span: RST_XSPAN};
            ycfg_reg <= '{lo: RST_LOW, hi: RST_HIGH, span: RST_YSPAN};
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_X_LOW:  xcfg_reg.lo   <= cfg_data;
                CFG_X_HIGH: xcfg_reg.hi   <= cfg_data;
                CFG_Y_LOW:  ycfg_reg.lo   <= cfg_data;
                CFG_Y_HIGH: ycfg_reg.hi   <= cfg_data;
                CFG_X_SPAN: xcfg_reg.span <= cfg_data;
                CFG_Y_SPAN: ycfg_reg.span <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= TS_IDLE;
            count_reg  <= '0;
            xtot_reg   <= '0;
            ytot_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            xtot_reg   <= xtot_next;
            ytot_reg   <= ytot_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign x_read  = s_tdata[READ_LSB +: READ_W];
    assign y_read  = s_tdata[WORD_W + READ_LSB +: READ_W];
    assign x_sum   = xtot_reg + TOTAL_W'(x_read);
    assign y_sum   = ytot_reg + TOTAL_W'(y_read);
    assign s_hs    = s_tvalid && s_tready;
    assign bad_cal = (xcfg_reg.hi <= xcfg_reg.lo) || (ycfg_reg.hi <= ycfg_reg.lo);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        xtot_next   = xtot_reg;
        ytot_next   = ytot_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mvalid_next = (mvalid_reg && m_tready) ? 1'b0 : mvalid_reg;
        s_tready    = 1'b0;
        start       = 1'b0;
        case (state_reg)
            TS_IDLE: begin
                s_tready = !mvalid_reg || m_tready;
                if (s_hs) begin
                    if (!s_tuser) begin
                        // release aborts the burst
                        count_next  = '0;
                        xtot_next   = '0;
                        ytot_next   = '0;
                        mvalid_next = 1'b1;
                        mdata_next  = '0;
                        muser_next  = 2'b00;
                    end else if (count_reg == CNT_W'(BURST_SAMPLES - 1)) begin
                        start      = 1'b1;
                        count_next = '0;
                        xtot_next  = '0;
                        ytot_next  = '0;
                        state_next = TS_CALC;
                    end else begin
                        count_next = count_reg + 1'b1;
                        xtot_next  = x_sum;
                        ytot_next  = y_sum;
                    end
                end
            end
            TS_CALC: begin
                if (x_done) begin
                    mvalid_next = 1'b1;
                    muser_next  = {bad_cal, 1'b1};
                    mdata_next  = bad_cal ? '0 : {y_coord, x_coord};
                    state_next  = TS_IDLE;
                end
            end
            default: begin
                state_next = TS_IDLE;
            end
        endcase
    end

    tsas_scale u_scale_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (start),
        .mean_i  (x_sum[TOTAL_W-1:CNT_W]),
        .cfg_i   (xcfg_reg),
        .done_o  (x_done),
        .coord_o (x_coord)
    );

    // runs in lockstep with the x unit
    tsas_scale u_scale_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (start),
        .mean_i  (y_sum[TOTAL_W-1:CNT_W]),
        .cfg_i   (ycfg_reg),
        .done_o  (y_done),
        .coord_o (y_coord)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // y_done is only a lockstep check on the shared start
    logic unused_done;
    assign unused_done = y_done;

endmodule

// File: rtl/tsas_checker.sv
`timescale 1ns / 1ps
`include "touch_sample_average_scale_top_defines.svh"

module tsas_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [31:0]                    s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [23:0]                    m_tdata,
    input logic [1:0]                     m_tuser,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [tsas_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [tsas_pkg::READ_W-1:0]    cfg_data
);

    // a stalled result holds
    `TSAS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // an aborted burst carries no coordinates and no calibration flag
    `TSAS_ASSERT_IMPLY(a_release_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 24'd0 && !m_tuser[1])

    // bad calibration zeroes both coordinates
    `TSAS_ASSERT_IMPLY(a_badcal_zero, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata == 24'd0)

    // a released item is answered in the next cycle
    `TSAS_ASSERT_NEXT(a_release_resp, aclk, aresetn, s_tvalid && s_tready && !s_tuser, m_tvalid && !m_tuser[0])

endmodule

bind touch_sample_average_scale_top tsas_checker u_tsas_checker (.*);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import tsas_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 166;
    localparam int PRESSURE_AT   = 1100;
    localparam int PRESSURE_LEN  = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic              pressed;
        logic [WORD_W-1:0] x_word;
        logic [WORD_W-1:0] y_word;
    } touch_sample_t;

    typedef struct {
        logic              touched;
        logic              bad_cal;
        logic [READ_W-1:0] screen_x;
        logic [READ_W-1:0] screen_y;
    } touch_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [READ_W-1:0]    cfg_data  = '0;

    touch_sample_t sample_q[$];
    touch_result_t touch_results_q[$];

    // own copy of calibration and burst accumulators
    logic [READ_W-1:0] cal_x_lo = RST_LOW;
    logic [READ_W-1:0] cal_x_hi = RST_HIGH;
    logic [READ_W-1:0] cal_y_lo = RST_LOW;
    logic [READ_W-1:0] cal_y_hi = RST_HIGH;
    logic [READ_W-1:0] cal_x_span = RST_XSPAN;
    logic [READ_W-1:0] cal_y_span = RST_YSPAN;
    int burst_count = 0;
    int x_sum = 0;
    int y_sum = 0;

    int  s_idle_pct = 7;
    int  m_idle_pct = 84;
    logic s_took = 1'b0;
    int  items_in = 0;
    int  queued = 0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  n_averaged = 0;
    int  n_released = 0;
    int  n_bad_cal = 0;
    int  n_settings = 1;
    int  cycles = 0;
    int  stall_left = 0;
    bit  stall_done = 1'b0;

    touch_sample_average_scale_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     touch_results_q.size());
            $display("** touch_sample_average_scale_top: FAILED **");
            $finish;
        end
    end

    function automatic logic [READ_W-1:0] scale_axis(int mean, logic [READ_W-1:0] lo,
                                                     logic [READ_W-1:0] hi,
                                                     logic [READ_W-1:0] span);
        int v;
        int lo_i;
        int hi_i;
        lo_i = lo;
        hi_i = hi;
        v = mean;
        if (v < lo_i) v = lo_i;
        if (v > hi_i) v = hi_i;
        return READ_W'(((v - lo_i) * int'(span)) / (hi_i - lo_i));
    endfunction

    task automatic average_and_scale(logic pressed, logic [WORD_W-1:0] xw,
                                     logic [WORD_W-1:0] yw);
        touch_result_t r;
        int mx;
        int my;
        r = '{1'b0, 1'b0, '0, '0};
        if (!pressed) begin
            // release aborts any burst and always reports not touched
            burst_count = 0;
            x_sum = 0;
            y_sum = 0;
            touch_results_q.push_back(r);
        end else begin
            x_sum += int'(xw[READ_LSB +: READ_W]);
            y_sum += int'(yw[READ_LSB +: READ_W]);
            burst_count++;
            if (burst_count >= BURST_SAMPLES) begin
                mx = x_sum / BURST_SAMPLES;
                my = y_sum / BURST_SAMPLES;
                burst_count = 0;
                x_sum = 0;
                y_sum = 0;
                r.touched = 1'b1;
                r.bad_cal = (cal_x_hi <= cal_x_lo) || (cal_y_hi <= cal_y_lo);
                if (!r.bad_cal) begin
                    r.screen_x = scale_axis(mx, cal_x_lo, cal_x_hi, cal_x_span);
                    r.screen_y = scale_axis(my, cal_y_lo, cal_y_hi, cal_y_span);
                end
                touch_results_q.push_back(r);
            end
        end
    endtask

    task automatic load_calibration(logic [CFG_IDX_W-1:0] idx, logic [READ_W-1:0] val);
        case (idx)
            CFG_X_LOW:  cal_x_lo = val;
            CFG_X_HIGH: cal_x_hi = val;
            CFG_Y_LOW:  cal_y_lo = val;
            CFG_Y_HIGH: cal_y_hi = val;
            CFG_X_SPAN: cal_x_span = val;
            CFG_Y_SPAN: cal_y_span = val;
            default: ;
        endcase
    endtask

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, act_val);
        end
    endtask

    // monitor: config, results and accepted items, all sampled at the rising edge
    always @(posedge aclk) begin
        touch_result_t exp_r;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) load_calibration(cfg_index, cfg_data);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (touch_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got tuser %b tdata %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    exp_r = touch_results_q.pop_front();
                    check_field("touched", int'(exp_r.touched), int'(m_tuser[0]));
                    check_field("bad_calibration", int'(exp_r.bad_cal), int'(m_tuser[1]));
                    check_field("screen_x", int'(exp_r.screen_x), int'(m_tdata[11:0]));
                    check_field("screen_y", int'(exp_r.screen_y), int'(m_tdata[23:12]));
                    if (!exp_r.touched) n_released++;
                    else n_averaged++;
                    if (exp_r.bad_cal) n_bad_cal++;
                end
            end
            if (s_tvalid && s_tready) begin
                items_in++;
                average_and_scale(s_tuser, s_tdata[15:0], s_tdata[31:16]);
            end
        end
    end

    // sample driver: valid is held until the item is taken
    always @(negedge aclk) begin
        touch_sample_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (sample_q.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                item = sample_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {item.y_word, item.x_word};
                s_tuser  <= item.pressed;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back up the input
    always @(negedge aclk) begin
        if (!stall_done && items_in >= PRESSURE_AT) begin
            stall_left = PRESSURE_LEN;
            stall_done = 1'b1;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    function automatic logic [WORD_W-1:0] make_word(int reading);
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        w[READ_LSB +: READ_W] = READ_W'(reading);
        return w;
    endfunction

    function automatic int pick_center();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return $urandom_range(0, 50);
        if (r == 1) return $urandom_range(4045, 4095);
        return $urandom_range(0, 4095);
    endfunction

    function automatic int near(int c);
        int v;
        v = c + int'($urandom_range(0, 80)) - 40;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    task automatic push_sample(logic pressed, logic [WORD_W-1:0] xw, logic [WORD_W-1:0] yw);
        sample_q.push_back('{pressed, xw, yw});
        queued++;
    endtask

    task automatic queue_burst(int cx, int cy, int len, bit scatter);
        for (int i = 0; i < len; i++) begin
            if (scatter)
                push_sample(1'b1, WORD_W'($urandom), WORD_W'($urandom));
            else
                push_sample(1'b1, make_word(near(cx)), make_word(near(cy)));
        end
    endtask

    task automatic queue_random_unit();
        int pick;
        int cx;
        int cy;
        pick = $urandom_range(0, 99);
        cx = pick_center();
        cy = pick_center();
        if (pick < 70) begin
            queue_burst(cx, cy, BURST_SAMPLES, $urandom_range(0, 7) == 0);
        end else if (pick < 85) begin
            // burst cut short by a release
            queue_burst(cx, cy, $urandom_range(1, BURST_SAMPLES - 1), 1'b0);
            push_sample(1'b0, WORD_W'($urandom), WORD_W'($urandom));
        end else if (pick < 93) begin
            push_sample(1'b0, WORD_W'($urandom), WORD_W'($urandom));
        end else begin
            repeat ($urandom_range(1, 6))
                push_sample(1'($urandom_range(0, 1)), WORD_W'($urandom), WORD_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || s_tvalid || touch_results_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [READ_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_calibration(int xl, int xh, int yl, int yh, int xs, int ys);
        wait_drained();
        write_reg(CFG_X_LOW, READ_W'(xl));
        write_reg(CFG_X_HIGH, READ_W'(xh));
        write_reg(CFG_Y_LOW, READ_W'(yl));
        write_reg(CFG_Y_HIGH, READ_W'(yh));
        write_reg(CFG_X_SPAN, READ_W'(xs));
        write_reg(CFG_Y_SPAN, READ_W'(ys));
        n_settings++;
    endtask

    initial begin
        int target;
        int lo;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 3) begin
                s_idle_pct = 7;
                m_idle_pct = 84;
            end else if (ph < 6) begin
                s_idle_pct = 84;
                m_idle_pct = 7;
            end else begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            case (ph)
                1: set_calibration(100, 3900, 200, 3800, 4095, 4095);
                2: begin
                    set_calibration(0, 4095, 0, 4095, 1, 1);
                    // spare indexes must leave the calibration alone
                    write_reg(CFG_SPARE_A, READ_W'($urandom));
                    write_reg(CFG_SPARE_B, READ_W'($urandom));
                end
                3: set_calibration(2048, 2048, 0, 4095, 320, 240);
                4: set_calibration(0, 4095, 4095, 0, 0, 4095);
                5: set_calibration(2000, 2001, 4094, 4095, 4095, 0);
                6: set_calibration($urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095));
                7: begin
                    lo = $urandom_range(0, 2000);
                    set_calibration(lo, $urandom_range(lo + 1, 4095), lo / 2,
                                    $urandom_range(lo / 2 + 1, 4095),
                                    $urandom_range(1, 4095), $urandom_range(1, 4095));
                end
                default: ;
            endcase
            if (ph == 0) begin
                // release with no burst running, then full-scale and zero readings
                push_sample(1'b0, 16'hFFFF, 16'hFFFF);
                repeat (BURST_SAMPLES) push_sample(1'b1, 16'hFFFF, 16'h0000);
                // only the ignored bits set on x, full reading on y
                repeat (3) push_sample(1'b1, 16'h8007, 16'h7FF8);
                push_sample(1'b0, 16'h0000, 16'h0000);
            end
            target = queued + PHASE_ITEMS;
            while (queued < target) queue_random_unit();
        end

        wait_drained();
        $display("run covered %0d samples and %0d results: %0d averaged, %0d released,",
                 items_in, results_seen, n_averaged, n_released);
        $display("%0d with bad calibration, across %0d calibration settings",
                 n_bad_cal, n_settings);
        if (mismatches == 0 && touch_results_q.size() == 0) begin
            $display("** touch_sample_average_scale_top: PASSED **");
        end else begin
            $display("** touch_sample_average_scale_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/tsas_pkg.sv
rtl/tsas_scale.sv
rtl/touch_sample_average_scale_top.sv
rtl/tsas_checker.sv
test/tb.sv
